// ===== hw/rtl/ssrt_pkg.sv =====
`timescale 1ns / 1ps

package ssrt_pkg;

	localparam int RING_DEPTH_DEF  = 256;
	localparam int CAPTURE_MAX_DEF = 4096;
	localparam int CFG_INDEX_W     = 3;

	// Request opcodes.
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_XCHG  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_LENGTH      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_TARGET    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_THRESHOLD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILL_BYTE         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_BULK_ENABLE       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_ENABLE    = 3'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_underflow;
		logic        push_accepted;
		logic        capture_valid;
		logic [11:0] capture_index;
		logic [7:0]  capture_byte;
		logic        gpio_updated;
		logic        gpio_level;
		logic        round_done;
		logic [7:0]  ring_used;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_op_t;

	typedef struct packed {
		logic       has_room;
		logic       has_data;
		logic [7:0] used_after;
	} ring_status_t;

endpackage

// ===== hw/rtl/ssrt_ring.sv =====
`timescale 1ns / 1ps

module ssrt_ring #(
	parameter int RING_DEPTH = ssrt_pkg::RING_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  ssrt_pkg::ring_op_t     op,
	input  logic [7:0]             wdata,
	output ssrt_pkg::ring_status_t status,
	output logic [7:0]             rdata
);
	import ssrt_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int CW = (PW + 1 > 8) ? PW + 1 : 8;
	localparam logic [PW:0]   DEPTH = (PW + 1)'(RING_DEPTH);
	localparam logic [PW-1:0] LAST  = PW'(RING_DEPTH - 1);

	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [7:0]    mem [RING_DEPTH];
	logic [PW:0]   count;
	logic [PW:0]   count_after;
	logic [CW-1:0] count_after_x;

	always_comb begin
		if (head_q >= tail_q) begin
			count = {1'b0, head_q} - {1'b0, tail_q};
		end else begin
			count = DEPTH - ({1'b0, tail_q} - {1'b0, head_q});
		end
		count_after = count + (PW + 1)'(op.push) - (PW + 1)'(op.pop);
		count_after_x = CW'(count_after);
		status.has_room = count < DEPTH - 1'b1;
		status.has_data = count != '0;
		status.used_after = (count_after_x > CW'(255)) ? 8'hFF : count_after_x[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (en) begin
			if (op.push) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
			end
			if (op.pop) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
			end
		end
	end

	// The read at the tail is taken on every advance; the pop decision only
	// moves the pointer.
	always_ff @(posedge clk) begin
		if (en && op.push) begin
			mem[head_q] <= wdata;
		end
		if (en) begin
			rdata <= mem[tail_q];
		end
	end

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		en && op.push |-> status.has_room)
		else $error("ring push while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		en && op.pop |-> status.has_data)
		else $error("ring pop while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && op.push && !op.pop |=> count == $past(count) + 1'b1)
		else $error("ring count did not follow push");
`endif

endmodule

// ===== hw/rtl/spi_slave_ring_threshold.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// cmd     | in        | cmd_valid / cmd_ready  | cmd (opcode, data_byte)
// res     | out       | res_valid / res_ready  | res (one result per request)
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while results are taken; after its request is accepted,
// a result passes the input register, ring read stage and output register in that order.
// The ring memory read at the tail is registered, so the window shift and threshold
// compare run in the stage after the ring pointers move.
// All stages advance together whenever the output register is empty or being taken;
// a stalled result holds the whole pipe. cfg_ready is always high.
// arst_n clears pointers, counters, flags and configuration; ring contents are not cleared.

module spi_slave_ring_threshold #(
	parameter int RING_DEPTH  = ssrt_pkg::RING_DEPTH_DEF,
	parameter int CAPTURE_MAX = ssrt_pkg::CAPTURE_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  ssrt_pkg::cmd_t                   cmd,
	output logic                             res_valid,
	input  logic                             res_ready,
	output ssrt_pkg::res_t                   res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ssrt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import ssrt_pkg::*;

	localparam int OW = $clog2(CAPTURE_MAX + 1);
	localparam int LW = (OW > 13) ? OW : 13;

	typedef struct packed {
		logic        xchg;
		logic        underflow;
		logic        push_ok;
		logic        cvalid;
		logic [11:0] cindex;
		logic [7:0]  cbyte;
		logic        tx_done;
		logic        done;
		logic [7:0]  used;
	} round_ctrl_t;

	// Configuration
	logic [7:0]  round_length_q;
	logic [12:0] capture_target_q;
	logic [31:0] threshold_q;
	logic [7:0]  fill_byte_q;
	logic        bulk_q;
	logic        capt_en_q;

	// Round state
	logic [7:0]    sent_count_q;
	logic [OW-1:0] offset_q;
	logic          done_q;
	logic [31:0]   window_q;
	logic          pin_q;

	// Pipeline
	logic          advance;
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic          valid_s2;
	round_ctrl_t   ctrl_s2;
	logic          res_valid_q;
	res_t          res_q;

	logic          fire_s1;
	logic          fire_s2;
	logic          is_push;
	logic          is_xchg;
	logic          is_start;
	ring_op_t      ring_op;
	ring_status_t  ring_status;
	logic [7:0]    ring_rdata;

	logic [LW-1:0] target_x;
	logic [LW-1:0] limit;
	logic [LW-1:0] offset_x;
	logic [LW-1:0] offset_next_x;
	logic          capture;
	logic [7:0]    count_inc;
	logic          tx_done;
	logic          rx_done;
	logic          done_next;
	round_ctrl_t   ctrl_s1;

	logic [7:0]    tx_s2;
	logic [31:0]   mask;
	logic [31:0]   win_shift;
	logic          pin_next;
	res_t          res_next;

	assign advance   = !res_valid_q || res_ready;
	assign cmd_ready = advance;
	assign fire_s1   = advance && valid_s1;
	assign fire_s2   = advance && valid_s2;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_length_q   <= '0;
			capture_target_q <= '0;
			threshold_q      <= '0;
			fill_byte_q      <= '0;
			bulk_q           <= 1'b0;
			capt_en_q        <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROUND_LENGTH:      round_length_q   <= cfg_data[7:0];
				CFG_CAPTURE_TARGET:    capture_target_q <= cfg_data[12:0];
				CFG_COMPARE_THRESHOLD: threshold_q      <= cfg_data;
				CFG_FILL_BYTE:         fill_byte_q      <= cfg_data[7:0];
				CFG_BULK_ENABLE:       bulk_q           <= cfg_data[0];
				CFG_CAPTURE_ENABLE:    capt_en_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: ring pointers, capture offset, sent count and done flag.
	always_comb begin
		is_push  = cmd_s1.opcode == OP_PUSH;
		is_xchg  = cmd_s1.opcode == OP_XCHG;
		is_start = cmd_s1.opcode == OP_START;

		ring_op.push = fire_s1 && is_push && ring_status.has_room;
		ring_op.pop  = fire_s1 && is_xchg && bulk_q && ring_status.has_data;

		target_x = LW'(capture_target_q);
		limit    = (target_x > LW'(CAPTURE_MAX)) ? LW'(CAPTURE_MAX) : target_x;
		offset_x = LW'(offset_q);
		capture  = is_xchg && capt_en_q && (offset_x < limit);
		offset_next_x = capture ? offset_x + 1'b1 : offset_x;

		count_inc = (sent_count_q != 8'hFF) ? sent_count_q + 1'b1 : sent_count_q;
		tx_done   = is_xchg && (round_length_q != '0) && (count_inc >= round_length_q);
		rx_done   = (limit != '0) && (offset_next_x >= limit);

		if (is_start) begin
			done_next = 1'b0;
		end else if (is_xchg) begin
			done_next = done_q || tx_done || rx_done;
		end else begin
			done_next = done_q;
		end

		ctrl_s1.xchg      = is_xchg;
		ctrl_s1.underflow = is_xchg && !(bulk_q && ring_status.has_data);
		ctrl_s1.push_ok   = is_push && ring_status.has_room;
		ctrl_s1.cvalid    = capture;
		ctrl_s1.cindex    = capture ? offset_x[11:0] : 12'd0;
		ctrl_s1.cbyte     = capture ? cmd_s1.data_byte : 8'd0;
		ctrl_s1.tx_done   = tx_done;
		ctrl_s1.done      = done_next;
		ctrl_s1.used      = ring_status.used_after;
	end

	ssrt_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.op    (ring_op),
		.wdata (cmd_s1.data_byte),
		.status(ring_status),
		.rdata (ring_rdata)
	);

	// Stage 2: window shift and threshold compare on the byte actually sent.
	always_comb begin
		tx_s2 = ctrl_s2.underflow ? fill_byte_q : ring_rdata;
		case (round_length_q)
			8'd0, 8'd1: mask = 32'h0000_00FF;
			8'd2:       mask = 32'h0000_FFFF;
			8'd3:       mask = 32'h00FF_FFFF;
			default:    mask = 32'hFFFF_FFFF;
		endcase
		win_shift = {window_q[23:0], tx_s2} & mask;
		pin_next  = ctrl_s2.tx_done ? (win_shift > (threshold_q & mask)) : pin_q;

		res_next.tx_byte       = ctrl_s2.xchg ? tx_s2 : 8'd0;
		res_next.tx_underflow  = ctrl_s2.underflow;
		res_next.push_accepted = ctrl_s2.push_ok;
		res_next.capture_valid = ctrl_s2.cvalid;
		res_next.capture_index = ctrl_s2.cindex;
		res_next.capture_byte  = ctrl_s2.cbyte;
		res_next.gpio_updated  = ctrl_s2.tx_done;
		res_next.gpio_level    = pin_next;
		res_next.round_done    = ctrl_s2.done;
		res_next.ring_used     = ctrl_s2.used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			res_valid_q  <= 1'b0;
			sent_count_q <= '0;
			offset_q     <= '0;
			done_q       <= 1'b0;
			window_q     <= '0;
			pin_q        <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd_valid;
			valid_s2    <= valid_s1;
			res_valid_q <= valid_s2;
			if (valid_s1) begin
				done_q   <= done_next;
				offset_q <= is_start ? '0 : OW'(offset_next_x);
				if (is_xchg) begin
					sent_count_q <= tx_done ? 8'd0 : count_inc;
				end
			end
			if (valid_s2 && ctrl_s2.xchg) begin
				window_q <= ctrl_s2.tx_done ? 32'd0 : win_shift;
				pin_q    <= pin_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1  <= cmd;
			ctrl_s2 <= ctrl_s1;
			res_q   <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	a_round_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && tx_done |=> sent_count_q == 8'd0)
		else $error("sent count not cleared at round end");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && is_start |=> !done_q && offset_q == '0)
		else $error("start did not clear done flag and capture offset");

	a_update_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 && ctrl_s2.tx_done |-> round_length_q != '0 && ctrl_s2.done)
		else $error("round ended without a round length or done flag");
`endif

endmodule
